// ===== sv/kmpst_pkg.sv =====
package kmpst_pkg;
  localparam int MaxNodes = 256;
  localparam int MaxEdges = 1024;
  localparam int NodeW = 8;
  localparam int EdgeAw = 10;
  localparam int CntW = 11;
  localparam int ProbW = 17;
  localparam int EdgeW = 2 * NodeW + ProbW;
  localparam int RankW = 4;
  localparam logic [ProbW-1:0] OneQ16 = 17'd65536;

  typedef enum logic [4:0] {
    ST_LOAD, ST_SORT_RD, ST_SORT_CMP, ST_SORT_WR, ST_INIT, ST_SCAN_RD, ST_SCAN_EV,
    ST_FA_RD, ST_FA_EV, ST_FB_RD, ST_FB_EV, ST_CA_RD, ST_CA_EV, ST_CB_RD, ST_CB_EV,
    ST_RANK_RD, ST_RANK_EV, ST_MUL, ST_RND, ST_OUT, ST_SORT_SH
  } state_e;

  typedef struct packed {
    logic [NodeW-1:0] a;
    logic [NodeW-1:0] b;
    logic [ProbW-1:0] p;
  } edge_t;
endpackage

// ===== sv/kruskal_max_product_spanning_tree_top.sv =====
// Loads one edge word per cycle into an edge memory while in its load state. On the
// word with tlast the block runs a stable insertion sort in that memory. Each edge
// goes through read, latch, compare and write states, and each shifted edge through
// another compare and write. It then sets the union-find memory to identity, one
// node per cycle, and scans edges in sorted order. Each find walks the parent memory
// one hop at a time, and a compression pass walks the same path again. A taken
// edge then goes through the rank union and the rounded product. The result word
// sits in an output register, so loading of the next set resumes at once. A second
// result waits until the first one is taken.
module kruskal_max_product_spanning_tree_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // src_node[7:0], dst_node[15:8], survival_prob[32:16], zero[39:33]
  input  logic [39:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // product[16:0], edges_used[24:17], status[26:25], zero[31:27]
  output logic [31:0] m_axis_tdata
);
  import kmpst_pkg::*;

  state_e state_q, state_d;
  logic [8:0] ncfg_q;
  logic [CntW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d;
  logic [ProbW-1:0] prod_q, prod_d;
  logic [NodeW-1:0] used_q, used_d;
  logic [1:0] flags_q, flags_d;
  logic [33:0] mul_q, mul_d;
  edge_t key_q, key_d, cur_q, cur_d;
  logic [NodeW-1:0] x_q, x_d, ra_q, ra_d, rb_q, rb_d, hop_q, hop_d;
  logic [RankW-1:0] rka_q, rka_d;
  logic [31:0] out_q, out_d;
  logic ov_q, ov_d;

  logic e_we; logic [EdgeAw-1:0] e_wa, e_ra; edge_t e_wd, e_rd;
  logic p_we; logic [NodeW-1:0] p_wa, p_ra, p_wd, p_rd;
  logic r_we; logic [NodeW-1:0] r_wa, r_ra; logic [RankW-1:0] r_wd, r_rd;

  kmpst_ram #(.Width(EdgeW), .Depth(MaxEdges)) u_edge (
    .clk_i, .we_i(e_we), .waddr_i(e_wa), .wdata_i(e_wd), .raddr_i(e_ra), .rdata_o(e_rd));
  kmpst_ram #(.Width(NodeW), .Depth(MaxNodes)) u_par (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd), .raddr_i(p_ra), .rdata_o(p_rd));
  kmpst_ram #(.Width(RankW), .Depth(MaxNodes)) u_rank (
    .clk_i, .we_i(r_we), .waddr_i(r_wa), .wdata_i(r_wd), .raddr_i(r_ra), .rdata_o(r_rd));

  logic [8:0] n_use;
  assign n_use = (ncfg_q == 9'd0) ? 9'd1 : ncfg_q;

  logic [NodeW-1:0] in_a, in_b; logic [ProbW-1:0] in_p;
  assign in_a = s_axis_tdata[7:0];
  assign in_b = s_axis_tdata[15:8];
  assign in_p = (s_axis_tdata[32:16] > OneQ16) ? OneQ16 : s_axis_tdata[32:16];

  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = out_q;

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;
  logic [17:0] rnd;
  assign rnd = 18'(mul_q[33:16]);

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q; prod_d = prod_q;
    used_d = used_q; flags_d = flags_q; mul_d = mul_q; key_d = key_q; cur_d = cur_q;
    x_d = x_q; ra_d = ra_q; rb_d = rb_q; hop_d = hop_q; rka_d = rka_q;
    out_d = out_q; ov_d = ov_q && !m_axis_tready;
    e_we = 1'b0; e_wa = cnt_q[EdgeAw-1:0]; e_wd = '0; e_ra = '0;
    p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = x_q;
    r_we = 1'b0; r_wa = '0; r_wd = '0; r_ra = ra_q;
    case (state_q)
      ST_LOAD: if (acc) begin
        if ({1'b0, in_a} >= n_use || {1'b0, in_b} >= n_use) flags_d[1] = 1'b1;
        else if (cnt_q == CntW'(MaxEdges)) flags_d[0] = 1'b1;
        else begin
          e_we = 1'b1; e_wd = '{a: in_a, b: in_b, p: in_p}; cnt_d = cnt_q + 1'b1;
        end
        if (s_axis_tlast) begin state_d = ST_SORT_RD; i_d = CntW'(1); end
      end
      ST_SORT_RD: begin
        if (i_q >= cnt_q) begin state_d = ST_INIT; x_d = '0; end
        else begin e_ra = i_q[EdgeAw-1:0]; state_d = ST_SORT_SH; end
      end
      ST_SORT_SH: begin key_d = e_rd; j_d = i_q; state_d = ST_SORT_CMP; end
      ST_SORT_CMP: begin
        if (j_q == '0) state_d = ST_SORT_WR;
        else begin e_ra = EdgeAw'(j_q - 1'b1); state_d = ST_SORT_WR; end
      end
      ST_SORT_WR: begin
        if (j_q != '0 && e_rd.p < key_q.p) begin
          e_we = 1'b1; e_wa = j_q[EdgeAw-1:0]; e_wd = e_rd; j_d = j_q - 1'b1;
          state_d = ST_SORT_CMP;
        end else begin
          e_we = 1'b1; e_wa = j_q[EdgeAw-1:0]; e_wd = key_q;
          i_d = i_q + 1'b1; state_d = ST_SORT_RD;
        end
      end
      ST_INIT: begin
        p_we = 1'b1; p_wa = x_q; p_wd = x_q; r_we = 1'b1; r_wa = x_q; r_wd = '0;
        x_d = x_q + 1'b1;
        if ({1'b0, x_q} == n_use - 1'b1) begin state_d = ST_SCAN_RD; i_d = '0; end
      end
      ST_SCAN_RD: begin
        if (i_q >= cnt_q || {1'b0, used_q} + 9'd1 >= n_use) state_d = ST_OUT;
        else begin e_ra = i_q[EdgeAw-1:0]; state_d = ST_SCAN_EV; end
      end
      ST_SCAN_EV: begin
        cur_d = e_rd; i_d = i_q + 1'b1;
        if ({1'b0, e_rd.a} >= n_use || {1'b0, e_rd.b} >= n_use) begin
          flags_d[1] = 1'b1; state_d = ST_SCAN_RD;
        end else begin x_d = e_rd.a; state_d = ST_FA_RD; end
      end
      ST_FA_RD: state_d = ST_FA_EV;
      ST_FA_EV: begin
        if (p_rd == x_q) begin ra_d = x_q; x_d = cur_q.b; state_d = ST_FB_RD; end
        else begin x_d = p_rd; state_d = ST_FA_RD; end
      end
      ST_FB_RD: state_d = ST_FB_EV;
      ST_FB_EV: begin
        if (p_rd == x_q) begin rb_d = x_q; x_d = cur_q.a; state_d = ST_CA_RD; end
        else begin x_d = p_rd; state_d = ST_FB_RD; end
      end
      ST_CA_RD: state_d = ST_CA_EV;
      ST_CA_EV: begin
        if (x_q == ra_q) begin x_d = cur_q.b; state_d = ST_CB_RD; end
        else begin
          p_we = 1'b1; p_wa = x_q; p_wd = ra_q; x_d = p_rd; state_d = ST_CA_RD;
        end
      end
      ST_CB_RD: state_d = ST_CB_EV;
      ST_CB_EV: begin
        if (x_q == rb_q) begin
          state_d = (ra_q == rb_q) ? ST_SCAN_RD : ST_RANK_RD;
        end else begin
          p_we = 1'b1; p_wa = x_q; p_wd = rb_q; x_d = p_rd; state_d = ST_CB_RD;
        end
      end
      ST_RANK_RD: begin r_ra = ra_q; hop_d = '0; state_d = ST_RANK_EV; end
      ST_RANK_EV: begin
        if (hop_q == '0) begin
          rka_d = r_rd; r_ra = rb_q; hop_d = 8'd1;
        end else begin
          if (rka_q < r_rd) begin p_we = 1'b1; p_wa = ra_q; p_wd = rb_q; end
          else begin
            p_we = 1'b1; p_wa = rb_q; p_wd = ra_q;
            if (rka_q == r_rd && rka_q != 4'd15) begin
              r_we = 1'b1; r_wa = ra_q; r_wd = rka_q + 1'b1;
            end
          end
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin mul_d = prod_q * cur_q.p + 34'd32768; state_d = ST_RND; end
      ST_RND: begin
        prod_d = (rnd > 18'(OneQ16)) ? OneQ16 : rnd[ProbW-1:0];
        used_d = used_q + 1'b1; state_d = ST_SCAN_RD;
      end
      ST_OUT: if (!ov_q || m_axis_tready) begin
        out_d = {5'd0, flags_q, used_q, prod_q}; ov_d = 1'b1;
        cnt_d = '0; prod_d = OneQ16; used_d = '0; flags_d = '0; state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD; ncfg_q <= 9'd256; cnt_q <= '0; prod_q <= OneQ16;
      used_q <= '0; flags_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; prod_q <= prod_d; used_q <= used_d;
      flags_q <= flags_d; ov_q <= ov_d;
      if (cfg_we_i) ncfg_q <= (cfg_wdata_i > 9'd256) ? 9'd256 : cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; mul_q <= mul_d; key_q <= key_d; cur_q <= cur_d;
    x_q <= x_d; ra_q <= ra_d; rb_q <= rb_d; hop_q <= hop_d; rka_q <= rka_d;
    out_q <= out_d;
  end

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxEdges)) else $error("edge count overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("result changed");
  a_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RND |-> {1'b0, used_q} + 9'd1 < n_use) else $error("too many edges");
endmodule

// ===== sv/kmpst_ram.sv =====
module kmpst_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sim/tb.sv =====
module tb;
  import kmpst_pkg::*;

  localparam int WatchdogLimit = 4000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [8:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // src_node[7:0], dst_node[15:8], survival_prob[32:16], zero[39:33]
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // product[16:0], edges_used[24:17], status[26:25], zero[31:27]
  logic [31:0] m_axis_tdata;

  kruskal_max_product_spanning_tree_top u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [16:0] product;
    logic [7:0]  used;
    logic [1:0]  status;
  } forest_t;

  // Forest model state.
  edge_t        mdl_edges[MaxEdges];
  int unsigned  mdl_count;
  logic [1:0]   mdl_flags;
  logic [8:0]   mdl_nodes = 9'd256;
  int unsigned  uf_parent[MaxNodes];
  int unsigned  uf_rank[MaxNodes];
  forest_t      forest_q[$];

  int errors = 0;
  int results_seen = 0;
  int words_sent = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit rx_random = 1'b1;

  function automatic int unsigned find_root(int unsigned x);
    int unsigned r;
    int unsigned nx;
    r = x;
    while (uf_parent[r] != r) r = uf_parent[r];
    while (x != r) begin
      nx = uf_parent[x];
      uf_parent[x] = r;
      x = nx;
    end
    return r;
  endfunction

  // Feeds one edge to the model and returns 1 with the forest when it closes a set.
  function automatic bit model_edge(input logic [7:0] a, input logic [7:0] b,
                                    input logic [16:0] p, input bit last,
                                    output forest_t res);
    int unsigned n;
    int unsigned prob;
    int unsigned ra;
    int unsigned rb;
    int unsigned used;
    longint unsigned prod;
    edge_t e;
    int j;
    n = (mdl_nodes == 0) ? 1 : (mdl_nodes > MaxNodes ? MaxNodes : mdl_nodes);
    prob = (p > OneQ16) ? OneQ16 : p;
    if (a >= n || b >= n) mdl_flags[1] = 1'b1;
    else if (mdl_count >= MaxEdges) mdl_flags[0] = 1'b1;
    else begin
      mdl_edges[mdl_count] = '{a: a, b: b, p: prob[16:0]};
      mdl_count++;
    end
    if (!last) return 1'b0;
    for (int i = 1; i < mdl_count; i++) begin
      e = mdl_edges[i];
      j = i;
      while (j > 0 && mdl_edges[j-1].p < e.p) begin
        mdl_edges[j] = mdl_edges[j-1];
        j--;
      end
      mdl_edges[j] = e;
    end
    for (int i = 0; i < n; i++) begin
      uf_parent[i] = i;
      uf_rank[i] = 0;
    end
    prod = OneQ16;
    used = 0;
    for (int i = 0; i < mdl_count && used + 1 < n; i++) begin
      e = mdl_edges[i];
      if (e.a >= n || e.b >= n) begin
        mdl_flags[1] = 1'b1;
        continue;
      end
      ra = find_root(e.a);
      rb = find_root(e.b);
      if (ra == rb) continue;
      if (uf_rank[ra] < uf_rank[rb]) uf_parent[ra] = rb;
      else if (uf_rank[ra] > uf_rank[rb]) uf_parent[rb] = ra;
      else begin
        uf_parent[rb] = ra;
        if (uf_rank[ra] < 15) uf_rank[ra]++;
      end
      prod = (prod * e.p + 32768) >> 16;
      if (prod > OneQ16) prod = OneQ16;
      used++;
    end
    res = '{product: prod[16:0], used: used[7:0], status: mdl_flags};
    mdl_count = 0;
    mdl_flags = '0;
    return 1'b1;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    forest_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (forest_q.size() == 0) report("unexpected word", m_axis_tdata, 0);
      else begin
        want = forest_q.pop_front();
        if (m_axis_tdata[16:0] !== want.product)
          report("product", 32'(m_axis_tdata[16:0]), 32'(want.product));
        if (m_axis_tdata[24:17] !== want.used)
          report("edges_used", 32'(m_axis_tdata[24:17]), 32'(want.used));
        if (m_axis_tdata[26:25] !== want.status)
          report("status", 32'(m_axis_tdata[26:25]), 32'(want.status));
        if (m_axis_tdata[31:27] !== '0) report("pad bits", 32'(m_axis_tdata[31:27]), 0);
      end
    end
  end

  // Receiver stall pattern.
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else if (!rx_random) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("watchdog expired with %0d results outstanding", forest_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  int burst_left = 0;

  task automatic send_edge(input logic [7:0] a, input logic [7:0] b,
                           input logic [16:0] p, input bit last);
    forest_t res;
    // A new burst always starts after a gap in which valid is low.
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, p, b, a};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if (model_edge(a, b, p, last, res)) forest_q.push_back(res);
    if (burst_left == 0 || last) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tlast <= 1'b0;
      burst_left = 0;
    end
  endtask

  task automatic drain();
    if (burst_left != 0) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 0;
    end
    while (forest_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_nodes(input logic [8:0] n);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= n;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mdl_nodes = n;
  endtask

  typedef struct {
    logic [7:0]  a;
    logic [7:0]  b;
    logic [16:0] p;
    bit          last;
    bit          known;
    forest_t     want;
  } row_t;

  // Directed rows; a typed-in result is checked against the model's answer.
  row_t directed[] = '{
    '{8'd0,   8'd0,   17'd65536, 1'b1, 1'b1, '{17'd65536, 8'd0, 2'd0}},
    '{8'd0,   8'd255, 17'd65536, 1'b1, 1'b1, '{17'd65536, 8'd1, 2'd0}},
    '{8'd0,   8'd1,   17'd0,     1'b1, 1'b1, '{17'd0,     8'd1, 2'd0}},
    '{8'd3,   8'd3,   17'd40000, 1'b1, 1'b1, '{17'd65536, 8'd0, 2'd0}},
    '{8'd1,   8'd2,   17'h1FFFF, 1'b1, 1'b1, '{17'd65536, 8'd1, 2'd0}},
    '{8'd1,   8'd2,   17'd32768, 1'b0, 1'b0, '{17'd0, 8'd0, 2'd0}},
    '{8'd2,   8'd3,   17'd32768, 1'b0, 1'b0, '{17'd0, 8'd0, 2'd0}},
    '{8'd1,   8'd3,   17'd49152, 1'b0, 1'b0, '{17'd0, 8'd0, 2'd0}},
    '{8'd4,   8'd5,   17'd1,     1'b0, 1'b0, '{17'd0, 8'd0, 2'd0}},
    '{8'd5,   8'd4,   17'd65535, 1'b1, 1'b0, '{17'd0, 8'd0, 2'd0}},
    '{8'd170, 8'd85,  17'd21845, 1'b0, 1'b0, '{17'd0, 8'd0, 2'd0}},
    '{8'd85,  8'd170, 17'd43690, 1'b1, 1'b0, '{17'd0, 8'd0, 2'd0}}
  };

  task automatic run_sets(input int words, input int max_set);
    int left;
    int n;
    logic [7:0] a;
    logic [7:0] b;
    logic [16:0] p;
    n = (mdl_nodes == 0) ? 1 : (mdl_nodes > MaxNodes ? MaxNodes : mdl_nodes);
    left = 0;
    for (int k = 0; k < words; k++) begin
      if (left == 0) left = $urandom_range(1, max_set);
      left--;
      if ($urandom_range(0, 19) == 0) begin
        a = 8'($urandom);
        b = 8'($urandom);
      end else begin
        a = 8'($urandom_range(0, n - 1));
        b = 8'($urandom_range(0, n - 1));
      end
      case ($urandom_range(0, 5))
        0: p = ($urandom_range(0, 3) == 0) ? 17'h1FFFF : 17'($urandom);
        1: p = OneQ16;
        2: p = {1'b0, 4'hF, 12'($urandom)};
        3: p = 17'($urandom_range(0, 4)) << 14;
        default: p = 17'($urandom_range(0, 65536));
      endcase
      send_edge(a, b, p, left == 0 || k == words - 1);
    end
  endtask

  initial begin
    forest_t res;
    mdl_count = 0;
    mdl_flags = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < directed.size(); i++) begin
      if (i == 3) set_nodes(9'd4);
      if (i == 5) set_nodes(9'd0);
      if (i == 6) set_nodes(9'd6);
      if (i == 10) set_nodes(9'd511);
      send_edge(directed[i].a, directed[i].b, directed[i].p, directed[i].last);
      if (directed[i].known && directed[i].last && forest_q[$] != directed[i].want)
        report("directed row", i, 0);
    end

    // Stored edges that fall outside a shrunken node count.
    set_nodes(9'd200);
    send_edge(8'd10, 8'd150, 17'd30000, 1'b0);
    send_edge(8'd1, 8'd2, 17'd30000, 1'b0);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= 9'd100;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mdl_nodes = 9'd100;
    send_edge(8'd3, 8'd4, 17'd60000, 1'b1);

    // Fill the edge memory past its end on a tiny graph.
    set_nodes(9'd2);
    rx_random = 1'b0;
    for (int i = 0; i < MaxEdges + 3; i++)
      send_edge(8'($urandom_range(0, 1)), 8'($urandom_range(0, 1)),
                17'($urandom), i == MaxEdges + 2);

    rx_random = 1'b1;
    set_nodes(9'd16);
    run_sets(100, 12);

    // Long receiver hold-off while the sender keeps offering edges.
    drain();
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      run_sets(30, 3);
    join

    set_nodes(9'd1);
    run_sets(30, 6);
    set_nodes(9'd256);
    run_sets(50, 20);
    set_nodes(9'd40);
    run_sets(50, 15);

    drain();
    repeat (200) @(posedge clk_i);
    $display("Ran %0d edge words into %0d spanning-forest results", words_sent, results_seen);
    $display("over node counts 0..511, full memory overflow and bad-node drops.");
    if (errors == 0 && forest_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== sim.f =====
sv/kmpst_pkg.sv
sv/kmpst_ram.sv
sv/kruskal_max_product_spanning_tree_top.sv
sim/tb.sv
